>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the path validator check logic.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define PSV_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, during reset as well.
`define PSV_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/psv_pkg.sv
// ---------------------------------------------------------------------------
// Path validator package
// Character codes and the payload types passed between the stages.
// ---------------------------------------------------------------------------
package psv_pkg;

  // Character codes that the rules refer to.
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_FIRST  = 8'h21;  // '!'
  localparam logic [7:0] CHAR_LAST   = 8'h7E;  // '~'
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;  // backslash
  localparam logic [7:0] CHAR_COLON  = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_DOT    = 8'h2E;  // '.'

  // Component length saturates here.
  localparam logic [1:0] SEG_LEN_MAX = 2'd3;

  // One input byte with its side field; root_en accepts the lone root path.
  typedef struct packed {
    logic [7:0] character;
    logic       root_en;
  } psv_item_t;

  // Result produced by the check logic for one byte.
  typedef struct packed {
    logic valid;
    logic path_ok;
  } psv_result_t;

endpackage

>>> sv/psv_char_if.sv
// ---------------------------------------------------------------------------
// Path byte channel
// Valid/ready channel that carries one path byte per transaction.
// ---------------------------------------------------------------------------
interface psv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       root_en;

  modport source (output valid, output character, output root_en, input ready);
  modport sink   (input valid, input character, input root_en, output ready);
endinterface

>>> sv/psv_result_if.sv
// ---------------------------------------------------------------------------
// Path verdict channel
// Valid/ready channel that carries one verdict bit per transaction.
// ---------------------------------------------------------------------------
interface psv_result_if;
  logic valid;
  logic ready;
  logic path_ok;

  modport source (output valid, output path_ok, input ready);
  modport sink   (input valid, input path_ok, output ready);
endinterface

>>> sv/psv_in_stage.sv
// ---------------------------------------------------------------------------
// Path validator input register
// Holds one incoming byte until the check logic consumes it.
// ---------------------------------------------------------------------------
module psv_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  psv_pkg::psv_item_t item_i,
  output logic              ready_o,
  input  logic              take_i,
  output logic              valid_o,
  output psv_pkg::psv_item_t item_o
);

  logic               valid_q;
  psv_pkg::psv_item_t item_q;

  // The register is free when empty or when its byte leaves this cycle.
  assign ready_o = !valid_q || take_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/psv_check.sv
// ---------------------------------------------------------------------------
// Path validator check logic
// Per-path counters and flags, updated by one byte per cycle when take_i is set.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psv_check #(
  parameter int PATH_SIZE = 64,
  parameter int MAX_DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  psv_pkg::psv_item_t   item_i,
  output psv_pkg::psv_result_t result_o
);

  localparam int CW = $clog2(PATH_SIZE);
  localparam int SW = $clog2(MAX_DEPTH + 1);
  localparam logic [CW-1:0] CNT_LIMIT = CW'(PATH_SIZE - 1);
  localparam logic [SW-1:0] DEPTH_LIMIT = SW'(MAX_DEPTH);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    seg_len_q, seg_len_d;
  logic          dots_q, dots_d;
  logic [SW-1:0] seg_cnt_q, seg_cnt_d;
  logic          first_q, first_d;
  logic          failed_q, failed_d;

  logic [7:0] c;
  logic       is_term;
  logic       bad_char;
  logic       close_ok;
  logic       path_ok;

  assign c       = item_i.character;
  assign is_term = (c == psv_pkg::CHAR_NUL);

  // Byte outside the '!' to '~' range, or a forbidden separator.
  assign bad_char = (c < psv_pkg::CHAR_FIRST) || (c > psv_pkg::CHAR_LAST) ||
                    (c == psv_pkg::CHAR_BSLASH) || (c == psv_pkg::CHAR_COLON);

  // The current component may close: non-empty, not a dot name, depth left.
  assign close_ok = (seg_len_q != 2'd0) &&
                    !(dots_q && (seg_len_q == 2'd1 || seg_len_q == 2'd2)) &&
                    (seg_cnt_q < DEPTH_LIMIT);

  // Verdict at the terminator; a lone root depends on root_en only.
  always_comb begin
    if (failed_q) begin
      path_ok = 1'b0;
    end else if (first_q && cnt_q == CW'(1)) begin
      path_ok = item_i.root_en;
    end else begin
      path_ok = close_ok;
    end
  end

  // Next state for one consumed byte.
  always_comb begin
    cnt_d     = cnt_q;
    seg_len_d = seg_len_q;
    dots_d    = dots_q;
    seg_cnt_d = seg_cnt_q;
    first_d   = first_q;
    failed_d  = failed_q;
    if (take_i) begin
      if (is_term) begin
        cnt_d     = '0;
        seg_len_d = 2'd0;
        dots_d    = 1'b1;
        seg_cnt_d = '0;
        first_d   = 1'b0;
        failed_d  = 1'b0;
      end else if (!failed_q) begin
        if (cnt_q >= CNT_LIMIT || bad_char) begin
          failed_d = 1'b1;
        end else if (c != psv_pkg::CHAR_SLASH) begin
          if (seg_len_q != psv_pkg::SEG_LEN_MAX) begin
            seg_len_d = seg_len_q + 2'd1;
          end
          if (c != psv_pkg::CHAR_DOT) begin
            dots_d = 1'b0;
          end
          cnt_d = cnt_q + CW'(1);
        end else if (cnt_q == '0) begin
          first_d = 1'b1;
          cnt_d   = cnt_q + CW'(1);
        end else if (!close_ok) begin
          failed_d = 1'b1;
        end else begin
          seg_cnt_d = seg_cnt_q + SW'(1);
          seg_len_d = 2'd0;
          dots_d    = 1'b1;
          cnt_d     = cnt_q + CW'(1);
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      seg_len_q <= 2'd0;
      dots_q    <= 1'b1;
      seg_cnt_q <= '0;
      first_q   <= 1'b0;
      failed_q  <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      seg_len_q <= seg_len_d;
      dots_q    <= dots_d;
      seg_cnt_q <= seg_cnt_d;
      first_q   <= first_d;
      failed_q  <= failed_d;
    end
  end

  assign result_o.valid   = take_i && is_term;
  assign result_o.path_ok = path_ok;

  // The byte count stops at the size limit.
  `PSV_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_LIMIT, "byte count passed the size limit")
  // The component count never passes the depth limit.
  `PSV_ASSERT(a_depth_bound, clk_i, rst_ni, seg_cnt_q <= DEPTH_LIMIT, "component count too high")
  // A terminator clears both counts and the fail flag and sets the dot flag.
  `PSV_ASSERT(a_term_clears, clk_i, rst_ni,
    take_i && is_term |=> cnt_q == '0 && seg_cnt_q == '0 && !failed_q && dots_q,
    "state not cleared after terminator")
  // A verdict is only produced for a consumed terminator.
  `PSV_ASSERT_ALWAYS(a_result_term, clk_i,
    result_o.valid |-> take_i && item_i.character == psv_pkg::CHAR_NUL,
    "verdict without terminator")

endmodule

>>> sv/psv_out_stage.sv
// ---------------------------------------------------------------------------
// Path validator output register
// Holds a verdict until the downstream side takes it.
// ---------------------------------------------------------------------------
module psv_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psv_pkg::psv_result_t result_i,
  output logic                 space_o,
  output logic                 valid_o,
  output logic                 path_ok_o,
  input  logic                 ready_i
);

  logic valid_q;
  logic ok_q;

  // Room for a new verdict when empty or when the held one leaves now.
  assign space_o = !valid_q || ready_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= result_i.valid;
    end
  end

  // Verdict bit.
  always_ff @(posedge clk_i) begin
    if (space_o && result_i.valid) begin
      ok_q <= result_i.path_ok;
    end
  end

  assign valid_o   = valid_q;
  assign path_ok_o = ok_q;

endmodule

>>> sv/path_string_validator.sv
// ---------------------------------------------------------------------------
// Path string validator
// Checks a zero-terminated path, one byte per transaction, and returns one
// verdict bit per path.
// ---------------------------------------------------------------------------
//   channel | dir | payload                 | transaction
//   in_i    | in  | character, root_en      | one path byte
//   out_o   | out | path_ok                 | one verdict, at each terminator
//
// One byte per cycle is taken while the output register has room; a byte is
// held in the input register and its verdict, if any, is then registered in
// the output register. The check logic between the two registers sets the rate.
// Reset clears both valid flags and resets all per-path counters and flags.
// A stalled verdict holds back only bytes once the input register is full.
// ---------------------------------------------------------------------------
module path_string_validator #(
  parameter int PATH_SIZE = 64,
  parameter int MAX_DEPTH = 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  psv_char_if.sink     in_i,
  psv_result_if.source out_o
);

  psv_pkg::psv_item_t   in_item;
  psv_pkg::psv_item_t   stage_item;
  psv_pkg::psv_result_t result;
  logic                 stage_valid;
  logic                 out_space;
  logic                 take;

  assign in_item.character = in_i.character;
  assign in_item.root_en   = in_i.root_en;

  // A byte is consumed when the verdict register can take any result.
  assign take = stage_valid && out_space;

  psv_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .item_i  (in_item),
    .ready_o (in_i.ready),
    .take_i  (take),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  psv_check #(
    .PATH_SIZE (PATH_SIZE),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .item_i   (stage_item),
    .result_o (result)
  );

  psv_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .result_i  (result),
    .space_o   (out_space),
    .valid_o   (out_o.valid),
    .path_ok_o (out_o.path_ok),
    .ready_i   (out_o.ready)
  );

endmodule

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// Path string validator testbench
// Sends zero-terminated paths byte by byte into the validator and checks
// each verdict against a cycle-free model of the path rules. The run covers
// directed corner cases, the length and depth limits, a long stall on the
// verdict side, and random well-formed, broken and noise paths.
// ---------------------------------------------------------------------------
module testbench;

  localparam int PATH_SIZE     = 64;
  localparam int MAX_DEPTH     = 8;
  localparam int ITEM_TARGET   = 1050;
  localparam int SETTLE_CYCLES = 10;
  localparam int TIME_LIMIT    = 2_000_000;
  localparam int HOLD_CYCLES   = 200;

  typedef logic [7:0] byte_q_t[$];

  logic clk_i = 1'b0;
  logic rst_ni;

  psv_char_if   char_if ();
  psv_result_if verdict_if ();

  path_string_validator #(
    .PATH_SIZE (PATH_SIZE),
    .MAX_DEPTH (MAX_DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .out_o  (verdict_if)
  );

  // Model state for the path being received.
  int         path_len;
  logic [1:0] comp_len;
  bit         comp_only_dots;
  int         comp_total;
  bit         lead_slash;
  bit         path_broken;

  // Verdicts still owed by the block, oldest first.
  bit pending_verdicts[$];

  int error_count;
  int bytes_sent;
  int burst_left;
  int hold_cycles;
  bit sender_nonstop;

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Path rule model
  // ------------------------------------------------------------------------

  function automatic void clear_path_state();
    path_len       = 0;
    comp_len       = '0;
    comp_only_dots = 1'b1;
    comp_total     = 0;
    lead_slash     = 1'b0;
    path_broken    = 1'b0;
  endfunction

  // Ends the current component; returns 0 when that breaks a rule.
  function automatic bit close_component();
    if (comp_len == 0 || (comp_only_dots && comp_len <= 2)) return 1'b0;
    if (comp_total + 1 > MAX_DEPTH) return 1'b0;
    comp_total++;
    comp_len       = '0;
    comp_only_dots = 1'b1;
    return 1'b1;
  endfunction

  // Applies one accepted byte and queues the verdict that a terminator owes.
  function automatic void judge_byte(input psv_pkg::psv_item_t item);
    logic [7:0] ch;
    ch = item.character;
    if (ch == psv_pkg::CHAR_NUL) begin
      if (path_broken) pending_verdicts.push_back(1'b0);
      else if (lead_slash && path_len == 1) pending_verdicts.push_back(item.root_en);
      else pending_verdicts.push_back(close_component());
      clear_path_state();
    end else if (!path_broken) begin
      if (path_len >= PATH_SIZE - 1 ||
          ch < psv_pkg::CHAR_FIRST || ch > psv_pkg::CHAR_LAST ||
          ch == psv_pkg::CHAR_BSLASH || ch == psv_pkg::CHAR_COLON) begin
        path_broken = 1'b1;
      end else if (ch != psv_pkg::CHAR_SLASH) begin
        if (comp_len < psv_pkg::SEG_LEN_MAX) comp_len++;
        if (ch != psv_pkg::CHAR_DOT) comp_only_dots = 1'b0;
        path_len++;
      end else if (path_len == 0) begin
        lead_slash = 1'b1;
        path_len++;
      end else if (!close_component()) begin
        path_broken = 1'b1;
      end else begin
        path_len++;
      end
    end
  endfunction

  // ------------------------------------------------------------------------
  // Path generators
  // ------------------------------------------------------------------------

  // A byte that may stand inside a component; dots come up often.
  function automatic logic [7:0] name_char();
    logic [7:0] ch;
    if ($urandom_range(0, 4) == 0) return psv_pkg::CHAR_DOT;
    do ch = 8'($urandom_range(psv_pkg::CHAR_FIRST, psv_pkg::CHAR_LAST));
    while (ch == psv_pkg::CHAR_SLASH || ch == psv_pkg::CHAR_BSLASH ||
           ch == psv_pkg::CHAR_COLON);
    return ch;
  endfunction

  // Body of the given length with a slash every stride bytes, never at the end.
  function automatic void make_spaced_path(input int total, input int stride,
                                           input bit lead, output byte_q_t text);
    logic [7:0] ch;
    text = {};
    if (lead) text.push_back(psv_pkg::CHAR_SLASH);
    for (int i = 0; i < total; i++) begin
      if (i % stride == stride - 1 && i != total - 1) begin
        text.push_back(psv_pkg::CHAR_SLASH);
      end else begin
        do ch = name_char();
        while (ch == psv_pkg::CHAR_DOT);
        text.push_back(ch);
      end
    end
  endfunction

  // Mostly well-formed paths with random content; some broken, some noise.
  function automatic void make_path(output byte_q_t text);
    int comps;
    int len;
    int kind;
    text = {};
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      len = $urandom_range(0, 8);
      repeat (len) text.push_back(8'($urandom_range(1, 255)));
      return;
    end
    if ($urandom_range(0, 1) == 1) text.push_back(psv_pkg::CHAR_SLASH);
    // Lone root or empty path.
    if (kind == 1) return;
    comps = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 4);
    for (int c = 0; c < comps; c++) begin
      if (c > 0) text.push_back(psv_pkg::CHAR_SLASH);
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 4);
      repeat (len) text.push_back(name_char());
    end
    // Break the structure in one of a few ways.
    if (kind == 2) begin
      case ($urandom_range(0, 2))
        0:       text.insert($urandom_range(0, text.size()), 8'($urandom_range(1, 255)));
        1:       text.push_back(psv_pkg::CHAR_SLASH);
        default: text.insert($urandom_range(0, text.size()), psv_pkg::CHAR_SLASH);
      endcase
    end
  endfunction

  // ------------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------------

  // Offers one byte, with a random gap at the start of each burst.
  task automatic send_item(input psv_pkg::psv_item_t item);
    int gap;
    if (!sender_nonstop && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk_i);
        char_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    char_if.valid     <= 1'b1;
    char_if.character <= item.character;
    char_if.root_en   <= item.root_en;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    judge_byte(item);
    bytes_sent++;
  endtask

  // Sends the bytes of a path followed by its terminator.
  task automatic send_path(input byte_q_t text, input logic root);
    psv_pkg::psv_item_t item;
    foreach (text[i]) begin
      item.character = text[i];
      item.root_en   = 1'($urandom_range(0, 1));
      send_item(item);
    end
    item.character = psv_pkg::CHAR_NUL;
    item.root_en   = root;
    send_item(item);
  endtask

  task automatic send_text(input string s, input logic root);
    byte_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_path(text, root);
  endtask

  task automatic send_lone_byte(input logic [7:0] ch, input logic root);
    byte_q_t text;
    text.push_back(ch);
    send_path(text, root);
  endtask

  // ------------------------------------------------------------------------
  // Receiver and checker
  // ------------------------------------------------------------------------

  // Stall pattern on the verdict side, with an optional long hold-off.
  initial begin : verdict_receiver
    int stall_pct;
    int pattern_left;
    stall_pct        = 0;
    pattern_left     = 0;
    verdict_if.ready = 1'b0;
    while (rst_ni !== 1'b1) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        verdict_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(10, 60);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        pattern_left--;
        verdict_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    error_count++;
  endtask

  // Compares each verdict transaction with the oldest one owed.
  always @(posedge clk_i) begin : verdict_check
    bit want;
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict arrived with no path pending");
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_if.path_ok !== want)
          report_mismatch($sformatf("path_ok is %b, expected %b", verdict_if.path_ok, want));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Empty path, lone root, character range, forbidden bytes and dot names.
  task automatic test_special_cases();
    send_text("", 1'b1);
    send_text("/", 1'b1);
    send_text("/", 1'b0);
    send_text("!~", 1'b0);
    send_lone_byte(psv_pkg::CHAR_FIRST - 8'd1, 1'b1);
    send_lone_byte(psv_pkg::CHAR_LAST + 8'd1, 1'b1);
    send_lone_byte(8'hFF, 1'b1);
    send_lone_byte(psv_pkg::CHAR_BSLASH, 1'b1);
    // Bytes after the colon are ignored until the terminator.
    send_text(":ab", 1'b1);
    send_text("..", 1'b1);
    send_text("../a", 1'b0);
    send_text("a/.", 1'b1);
    send_text("/a/", 1'b1);
    send_text("...", 1'b0);
  endtask

  // Paths right at and just past the size and depth limits.
  task automatic test_limits();
    byte_q_t text;
    make_spaced_path(PATH_SIZE - 1, 8, 1'b0, text);
    send_path(text, 1'($urandom_range(0, 1)));
    make_spaced_path(PATH_SIZE, 8, 1'b0, text);
    send_path(text, 1'($urandom_range(0, 1)));
    make_spaced_path(PATH_SIZE - 2, 8, 1'b1, text);
    send_path(text, 1'($urandom_range(0, 1)));
    make_spaced_path(PATH_SIZE - 1, 8, 1'b1, text);
    send_path(text, 1'($urandom_range(0, 1)));
    make_spaced_path(2 * MAX_DEPTH - 1, 2, 1'b0, text);
    send_path(text, 1'($urandom_range(0, 1)));
    make_spaced_path(2 * MAX_DEPTH + 1, 2, 1'b0, text);
    send_path(text, 1'($urandom_range(0, 1)));
    make_spaced_path(2 * MAX_DEPTH - 1, 2, 1'b1, text);
    send_path(text, 1'($urandom_range(0, 1)));
    make_spaced_path(2 * MAX_DEPTH + 1, 2, 1'b1, text);
    send_path(text, 1'($urandom_range(0, 1)));
  endtask

  // The verdict side holds off while bytes keep coming, so the block backs up.
  task automatic test_backpressure();
    sender_nonstop = 1'b1;
    hold_cycles    = HOLD_CYCLES;
    repeat (10) begin
      send_text("x", 1'b1);
      send_text("ab/c", 1'b0);
    end
    sender_nonstop = 1'b0;
  endtask

  task automatic test_random();
    byte_q_t text;
    while (bytes_sent < ITEM_TARGET) begin
      make_path(text);
      send_path(text, 1'($urandom_range(0, 1)));
    end
  endtask

  // ------------------------------------------------------------------------
  // Run control
  // ------------------------------------------------------------------------

  initial begin : main_sequence
    rst_ni            = 1'b0;
    char_if.valid     = 1'b0;
    char_if.character = psv_pkg::CHAR_NUL;
    char_if.root_en   = 1'b0;
    error_count       = 0;
    bytes_sent        = 0;
    burst_left        = 0;
    hold_cycles       = 0;
    sender_nonstop    = 1'b0;
    clear_path_state();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_special_cases();
    test_limits();
    test_backpressure();
    test_random();

    @(negedge clk_i);
    char_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS path_string_validator");
    end else begin
      $display("FAIL path_string_validator");
    end
    $finish;
  end

  // Ends a hung run.
  initial begin : watchdog
    #(TIME_LIMIT);
    $display("FAIL path_string_validator");
    $finish;
  end

endmodule
